>>> src/arp_responder_with_cache_macros.svh
// Assertion shorthands, sampled on clk and disabled while rst_n is low
`ifndef ARP_RESPONDER_WITH_CACHE_MACROS_SVH
`define ARP_RESPONDER_WITH_CACHE_MACROS_SVH

// same-cycle implication
`define ARPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arpc assertion failed");

// next-cycle implication
`define ARPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arpc assertion failed");

`endif

>>> src/arpc_pkg.sv
package arpc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] REQ_PKT     = 2'd0;
    localparam logic [1:0] REQ_LOOKUP  = 2'd1;
    localparam logic [1:0] REQ_RESOLVE = 2'd2;

    localparam logic [15:0] HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] PKT_OP_REQUEST = 16'd1;
    localparam logic [15:0] PKT_OP_REPLY   = 16'd2;

    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_REPLY   = 2'd2;

    localparam logic [2:0] ACT_IGNORED = 3'd0;
    localparam logic [2:0] ACT_REPLY   = 3'd1;
    localparam logic [2:0] ACT_REQUEST = 3'd2;
    localparam logic [2:0] ACT_LOOKUP  = 3'd3;
    localparam logic [2:0] ACT_WRITTEN = 3'd4;
    localparam logic [2:0] ACT_FULL    = 3'd5;

    localparam logic [0:0] CFG_OWN_MAC = 1'b0;
    localparam logic [0:0] CFG_OWN_IP  = 1'b1;

    localparam logic [47:0] BCAST_MAC = {48{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_WRITE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

    typedef struct packed {
        logic load;
        logic clr_idx;
        logic rd_en;
        logic inc_idx;
        logic mark_hit;
        logic wr_en;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_search;
        logic is_store;
        logic idx_end;
        logic match;
    } status_t;

endpackage

>>> src/arpc_ctrl.sv
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (!st.is_search)
                    state_next = S_FINISH;
                else if (st.idx_end)
                    state_next = st.is_store ? S_WRITE : S_FINISH;
                else
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (st.match)
                    state_next = st.is_store ? S_WRITE : S_FINISH;
                else
                    state_next = S_READ;
            end
            S_WRITE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load    = in_valid;
                cmd.clr_idx = in_valid;
            end
            S_READ:
            begin
                cmd.rd_en = st.is_search && !st.idx_end;
            end
            S_CMP:
            begin
                cmd.mark_hit = st.match;
                cmd.inc_idx  = !st.match;
            end
            S_WRITE:
            begin
                cmd.wr_en = 1'b1;
            end
            S_FINISH:
            begin
                cmd.out_load = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/arpc_dp.sv
module arpc_dp
    import arpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic        cfg_wr,
    input  logic [0:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic [1:0]  req_type,
    input  logic [15:0] pkt_htype,
    input  logic [15:0] pkt_ptype,
    input  logic [15:0] pkt_opcode,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [31:0] pkt_target_ip,
    input  logic [31:0] query_ip,
    output logic [2:0]  action,
    output logic [47:0] frame_dest_mac,
    output logic [1:0]  frame_opcode,
    output logic [47:0] frame_target_mac,
    output logic [31:0] frame_target_ip,
    output logic [47:0] found_mac,
    output logic        found
);

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;

    logic [1:0]  req_reg;
    logic [15:0] htype_reg;
    logic [15:0] ptype_reg;
    logic [15:0] opcode_reg;
    logic [47:0] smac_reg;
    logic [31:0] sip_reg;
    logic [31:0] tip_reg;
    logic [31:0] qip_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             hit_reg;
    logic             stored_reg;
    logic [47:0]      hitmac_reg;
    entry_t           rd_reg;
    entry_t           mem [TABLE_ENTRIES];

    logic [2:0]  action_reg;
    logic [47:0] dest_mac_reg;
    logic [1:0]  fop_reg;
    logic [47:0] tmac_reg;
    logic [31:0] tip_out_reg;
    logic [47:0] fmac_reg;
    logic        found_reg;

    logic [2:0]  action_next;
    logic [47:0] dest_mac_next;
    logic [1:0]  fop_next;
    logic [47:0] tmac_next;
    logic [31:0] tip_out_next;
    logic [47:0] fmac_next;
    logic        found_next;

    logic        pkt_ok;
    logic        is_store;
    logic        full;
    logic        do_write;
    logic [31:0] key;
    logic [IDX_W-1:0] wr_addr;

    assign pkt_ok   = (htype_reg == HTYPE_ETH) && (ptype_reg == PTYPE_IPV4);
    assign is_store = (req_reg == REQ_PKT) && pkt_ok && (opcode_reg == PKT_OP_REPLY);
    assign key      = (req_reg == REQ_LOOKUP) ? qip_reg : sip_reg;
    assign full     = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign do_write = cmd.wr_en && (hit_reg || !full);
    assign wr_addr  = hit_reg ? idx_reg[IDX_W-1:0] : count_reg[IDX_W-1:0];

    assign st.is_search = is_store || (req_reg == REQ_LOOKUP);
    assign st.is_store  = is_store;
    assign st.idx_end   = (idx_reg == count_reg);
    assign st.match     = (rd_reg.ip == key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_OWN_MAC: own_mac_reg <= cfg_data;
                CFG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                default:     own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type;
            htype_reg  <= pkt_htype;
            ptype_reg  <= pkt_ptype;
            opcode_reg <= pkt_opcode;
            smac_reg   <= sender_mac;
            sip_reg    <= sender_ip;
            tip_reg    <= pkt_target_ip;
            qip_reg    <= query_ip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            hit_reg    <= 1'b0;
            stored_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_idx)
            begin
                idx_reg    <= '0;
                hit_reg    <= 1'b0;
                stored_reg <= 1'b0;
            end
            else if (cmd.inc_idx)
                idx_reg <= idx_reg + CNT_W'(1);
            if (cmd.mark_hit)
                hit_reg <= 1'b1;
            if (cmd.wr_en)
                stored_reg <= hit_reg || !full;
            if (cmd.wr_en && !hit_reg && !full)
                count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_hit)
            hitmac_reg <= rd_reg.mac;
    end

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_addr] <= '{ip: key, mac: smac_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        action_next   = ACT_IGNORED;
        dest_mac_next = '0;
        fop_next      = OP_NONE;
        tmac_next     = '0;
        tip_out_next  = '0;
        fmac_next     = '0;
        found_next    = 1'b0;
        case (req_reg)
            REQ_PKT:
            begin
                if (is_store)
                    action_next = stored_reg ? ACT_WRITTEN : ACT_FULL;
                else if (pkt_ok && (opcode_reg == PKT_OP_REQUEST) && (tip_reg == own_ip_reg))
                begin
                    action_next   = ACT_REPLY;
                    dest_mac_next = smac_reg;
                    fop_next      = OP_REPLY;
                    tmac_next     = smac_reg;
                    tip_out_next  = sip_reg;
                end
            end
            REQ_LOOKUP:
            begin
                action_next = ACT_LOOKUP;
                found_next  = hit_reg;
                fmac_next   = hit_reg ? hitmac_reg : '0;
            end
            REQ_RESOLVE:
            begin
                action_next   = ACT_REQUEST;
                dest_mac_next = BCAST_MAC;
                fop_next      = OP_REQUEST;
                tmac_next     = BCAST_MAC;
                tip_out_next  = qip_reg;
            end
            default:
            begin
                action_next = ACT_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            action_reg   <= action_next;
            dest_mac_reg <= dest_mac_next;
            fop_reg      <= fop_next;
            tmac_reg     <= tmac_next;
            tip_out_reg  <= tip_out_next;
            fmac_reg     <= fmac_next;
            found_reg    <= found_next;
        end
    end

    assign action           = action_reg;
    assign frame_dest_mac   = dest_mac_reg;
    assign frame_opcode     = fop_reg;
    assign frame_target_mac = tmac_reg;
    assign frame_target_ip  = tip_out_reg;
    assign found_mac        = fmac_reg;
    assign found            = found_reg;

endmodule

>>> src/arp_responder_with_cache.sv
// Items that need no table search go from accept through S_READ and S_FINISH to out_valid.
// Lookups and stored replies read one entry at a time in S_READ and compare it in S_CMP, until
// an entry matches or all stored entries (at most 16) have been compared; a stored reply
// then passes S_WRITE for the table write, also when the table is full.
// One item in flight; the next is accepted the cycle after its result is registered, and
// an item waits in S_FINISH while out_ready holds the earlier result back.
// Reset (rst_n low, asynchronous) empties the table and clears own_mac and own_ip.
module arp_responder_with_cache
    import arpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] pkt_htype,
    input  logic [15:0] pkt_ptype,
    input  logic [15:0] pkt_opcode,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [31:0] pkt_target_ip,
    input  logic [31:0] query_ip,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [47:0] frame_dest_mac,
    output logic [1:0]  frame_opcode,
    output logic [47:0] frame_target_mac,
    output logic [31:0] frame_target_ip,
    output logic [47:0] found_mac,
    output logic        found,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    arpc_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .cfg_wr           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .pkt_htype        (pkt_htype),
        .pkt_ptype        (pkt_ptype),
        .pkt_opcode       (pkt_opcode),
        .sender_mac       (sender_mac),
        .sender_ip        (sender_ip),
        .pkt_target_ip    (pkt_target_ip),
        .query_ip         (query_ip),
        .action           (action),
        .frame_dest_mac   (frame_dest_mac),
        .frame_opcode     (frame_opcode),
        .frame_target_mac (frame_target_mac),
        .frame_target_ip  (frame_target_ip),
        .found_mac        (found_mac),
        .found            (found)
    );

endmodule

>>> src/arpc_checker.sv
`include "arp_responder_with_cache_macros.svh"

module arpc_checker
    import arpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  action,
    input logic [47:0] frame_dest_mac,
    input logic [1:0]  frame_opcode,
    input logic [47:0] found_mac,
    input logic        found
);

    // a stalled result holds
    `ARPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(action))

    // one item at a time
    `ARPC_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)

    `ARPC_ASSERT_IMP(a_miss_zero, out_valid && !found, found_mac == 48'd0)

    `ARPC_ASSERT_IMP(a_resolve_bcast, out_valid && (action == ACT_REQUEST), (frame_opcode == OP_REQUEST) && (frame_dest_mac == BCAST_MAC))

endmodule

bind arp_responder_with_cache arpc_checker u_arpc_checker (.*);

>>> bench/arp_responder_with_cache_test.sv
`timescale 1ns / 1ps

module arp_responder_with_cache_test;
    import arpc_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int POOL_SIZE = 24;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] htype;
        logic [15:0] ptype;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] query_ip;
    } arp_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] dest_mac;
        logic [1:0]  opcode;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
        logic [47:0] found_mac;
        logic        found;
    } arp_result_t;

    class arp_result_tracker;
        logic [47:0] station_mac = '0;
        logic [31:0] station_ip = '0;
        logic [31:0] cached_ip [TABLE_ENTRIES];
        logic [47:0] cached_mac [TABLE_ENTRIES];
        int unsigned cached_count = 0;
        arp_result_t owed_results [$];
        int unsigned mismatches = 0;
        int unsigned results_seen = 0;
        int unsigned action_tally [8];

        function void write_reg(logic [0:0] idx, logic [47:0] data);
            if (idx == CFG_OWN_MAC)
                station_mac = data;
            else
                station_ip = data[31:0];
        endfunction

        function int find_ip(logic [31:0] ip);
            int i;
            for (i = 0; i < cached_count; i++)
            begin
                if (cached_ip[i] == ip)
                    return i;
            end
            return -1;
        endfunction

        function logic [2:0] store_pair(logic [31:0] ip, logic [47:0] mac);
            int k;
            k = find_ip(ip);
            if (k >= 0)
            begin
                cached_mac[k] = mac;
                return ACT_WRITTEN;
            end
            if (cached_count >= TABLE_ENTRIES)
                return ACT_FULL;
            cached_ip[cached_count] = ip;
            cached_mac[cached_count] = mac;
            cached_count++;
            return ACT_WRITTEN;
        endfunction

        // work out the answer to an accepted item and queue it
        function logic [2:0] accept_item(arp_item_t it);
            arp_result_t r;
            int k;
            r = '0;
            r.action = ACT_IGNORED;
            case (it.req_type)
                REQ_PKT:
                begin
                    if (it.htype == HTYPE_ETH && it.ptype == PTYPE_IPV4)
                    begin
                        if (it.opcode == PKT_OP_REPLY)
                            r.action = store_pair(it.sender_ip, it.sender_mac);
                        else if (it.opcode == PKT_OP_REQUEST && it.target_ip == station_ip)
                        begin
                            r.action = ACT_REPLY;
                            r.dest_mac = it.sender_mac;
                            r.opcode = OP_REPLY;
                            r.target_mac = it.sender_mac;
                            r.target_ip = it.sender_ip;
                        end
                    end
                end
                REQ_LOOKUP:
                begin
                    r.action = ACT_LOOKUP;
                    k = find_ip(it.query_ip);
                    if (k >= 0)
                    begin
                        r.found_mac = cached_mac[k];
                        r.found = 1'b1;
                    end
                end
                REQ_RESOLVE:
                begin
                    r.action = ACT_REQUEST;
                    r.dest_mac = BCAST_MAC;
                    r.opcode = OP_REQUEST;
                    r.target_mac = BCAST_MAC;
                    r.target_ip = it.query_ip;
                end
                default:
                    r.action = ACT_IGNORED;
            endcase
            owed_results.push_back(r);
            return r.action;
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(arp_result_t got);
            arp_result_t want;
            results_seen++;
            if (owed_results.size() == 0)
            begin
                $error("result with nothing outstanding: action %0d", got.action);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            action_tally[want.action]++;
            compare_field("action", want.action, got.action);
            compare_field("frame_dest_mac", want.dest_mac, got.dest_mac);
            compare_field("frame_opcode", want.opcode, got.opcode);
            compare_field("frame_target_mac", want.target_mac, got.target_mac);
            compare_field("frame_target_ip", want.target_ip, got.target_ip);
            compare_field("found_mac", want.found_mac, got.found_mac);
            compare_field("found", want.found, got.found);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [15:0] pkt_htype = '0;
    logic [15:0] pkt_ptype = '0;
    logic [15:0] pkt_opcode = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic [31:0] pkt_target_ip = '0;
    logic [31:0] query_ip = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  action;
    logic [47:0] frame_dest_mac;
    logic [1:0]  frame_opcode;
    logic [47:0] frame_target_mac;
    logic [31:0] frame_target_ip;
    logic [47:0] found_mac;
    logic        found;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    arp_result_tracker tracker = new();
    logic [31:0] ip_pool [POOL_SIZE];
    bit steady = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned items_in = 0;
    int unsigned settings_applied = 0;

    arp_responder_with_cache DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .pkt_htype        (pkt_htype),
        .pkt_ptype        (pkt_ptype),
        .pkt_opcode       (pkt_opcode),
        .sender_mac       (sender_mac),
        .sender_ip        (sender_ip),
        .pkt_target_ip    (pkt_target_ip),
        .query_ip         (query_ip),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .action           (action),
        .frame_dest_mac   (frame_dest_mac),
        .frame_opcode     (frame_opcode),
        .frame_target_mac (frame_target_mac),
        .frame_target_ip  (frame_target_ip),
        .found_mac        (found_mac),
        .found            (found),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 37);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_result({action, frame_dest_mac, frame_opcode, frame_target_mac,
                                  frame_target_ip, found_mac, found});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transfer for %0d cycles", QUIET_LIMIT);
                $display("FAIL arp_responder_with_cache");
                $finish;
            end
        end
    end

    function automatic logic [15:0] r16();
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [31:0] r32();
        return $urandom();
    endfunction

    function automatic logic [47:0] r48();
        return {r16(), r32()};
    endfunction

    function automatic logic [31:0] pool_ip();
        return ip_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic arp_item_t compose(logic [1:0] kind, logic [15:0] htype,
                                          logic [15:0] ptype, logic [15:0] op,
                                          logic [47:0] smac, logic [31:0] sip,
                                          logic [31:0] tip, logic [31:0] qip);
        arp_item_t it;
        it.req_type = kind;
        it.htype = htype;
        it.ptype = ptype;
        it.opcode = op;
        it.sender_mac = smac;
        it.sender_ip = sip;
        it.target_ip = tip;
        it.query_ip = qip;
        return it;
    endfunction

    function automatic arp_item_t random_item();
        arp_item_t it;
        int pick;
        it = compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, r16(), r48(), r32(), r32(), r32());
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            it.opcode = PKT_OP_REPLY;
            if ($urandom_range(9) != 0)
                it.sender_ip = pool_ip();
            if ($urandom_range(9) == 0)
                it.sender_mac = '0;
        end
        else if (pick < 48)
        begin
            it.opcode = PKT_OP_REQUEST;
            if ($urandom_range(3) != 0)
                it.target_ip = tracker.station_ip;
            else if ($urandom_range(1) == 0)
                it.target_ip = pool_ip();
        end
        else if (pick < 73)
        begin
            it.req_type = REQ_LOOKUP;
            if ($urandom_range(6) != 0)
                it.query_ip = pool_ip();
        end
        else if (pick < 85)
        begin
            it.req_type = REQ_RESOLVE;
        end
        else
        begin
            it.req_type = 2'($urandom_range(3));
            if ($urandom_range(1) == 0)
                it.htype = r16();
            if ($urandom_range(1) == 0)
                it.ptype = r16();
            if ($urandom_range(1) == 0)
                it.opcode = 16'($urandom_range(3));
            if ($urandom_range(2) == 0)
                it.target_ip = tracker.station_ip;
            if ($urandom_range(1) == 0)
                it.sender_ip = pool_ip();
        end
        return it;
    endfunction

    task automatic send_item(input arp_item_t it, output logic [2:0] act);
        req_type <= it.req_type;
        pkt_htype <= it.htype;
        pkt_ptype <= it.ptype;
        pkt_opcode <= it.opcode;
        sender_mac <= it.sender_mac;
        sender_ip <= it.sender_ip;
        pkt_target_ip <= it.target_ip;
        query_ip <= it.query_ip;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        act = tracker.accept_item(it);
        items_in++;
    endtask

    task automatic await_results();
        do
            @(posedge clk);
        while (tracker.owed_results.size() != 0);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [47:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [47:0] mac, input logic [31:0] ip);
        write_reg(CFG_OWN_MAC, mac);
        write_reg(CFG_OWN_IP, {r16(), ip});
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic run_random(input int target, input bit no_gaps);
        int counted;
        logic [2:0] act;
        counted = 0;
        steady = no_gaps;
        while (counted < target)
        begin
            if ($urandom_range(59) == 0)
            begin
                in_valid <= 1'b0;
                await_results();
            end
            if (!steady && $urandom_range(99) < 37)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < 37);
            end
            send_item(random_item(), act);
            counted++;
        end
        steady = 1'b0;
        in_valid <= 1'b0;
        await_results();
    endtask

    initial
    begin : stimulus
        logic [2:0] act;
        logic [31:0] host_ip;
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            ip_pool[i] = r32();
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        host_ip = ip_pool[2];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, empty table
        send_item(compose(REQ_LOOKUP, r16(), r16(), r16(), r48(), r32(), r32(), '0), act);
        send_item(compose(REQ_RESOLVE, r16(), r16(), r16(), r48(), r32(), r32(), '0), act);
        send_item(compose(REQ_RESOLVE, r16(), r16(), r16(), r48(), r32(), r32(), '1), act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, PKT_OP_REQUEST, '1, '1, '0, r32()),
                  act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, PKT_OP_REQUEST, r48(), r32(), 32'd1,
                          r32()), act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, PKT_OP_REPLY, 48'h0200_0000_0001,
                          host_ip, r32(), r32()), act);
        send_item(compose(REQ_LOOKUP, r16(), r16(), r16(), r48(), r32(), r32(), host_ip), act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, PKT_OP_REPLY, '0, host_ip, r32(),
                          r32()), act);
        send_item(compose(REQ_LOOKUP, r16(), r16(), r16(), r48(), r32(), r32(), host_ip), act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, PKT_OP_REPLY, r48(), host_ip, r32(),
                          r32()), act);
        send_item(compose(REQ_LOOKUP, r16(), r16(), r16(), r48(), r32(), r32(), host_ip), act);
        send_item(compose(REQ_PKT, 16'h0000, PTYPE_IPV4, PKT_OP_REPLY, r48(), r32(), r32(),
                          r32()), act);
        send_item(compose(REQ_PKT, HTYPE_ETH, 16'h86DD, PKT_OP_REPLY, r48(), r32(), r32(),
                          r32()), act);
        send_item(compose(REQ_PKT, 16'hFFFF, 16'hFFFF, PKT_OP_REPLY, r48(), r32(), r32(),
                          r32()), act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, 16'd3, r48(), r32(), '0, r32()), act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, 16'hFFFF, r48(), r32(), '0, r32()),
                  act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, 16'd0, r48(), r32(), '0, r32()), act);
        send_item(compose(REQ_UNUSED, HTYPE_ETH, PTYPE_IPV4, PKT_OP_REPLY, r48(), r32(), '0,
                          r32()), act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, PKT_OP_REPLY, '1, '0, r32(), r32()),
                  act);
        send_item(compose(REQ_PKT, HTYPE_ETH, PTYPE_IPV4, PKT_OP_REPLY, 48'd1, '1, r32(),
                          r32()), act);
        send_item(compose(REQ_LOOKUP, r16(), r16(), r16(), r48(), r32(), r32(), '1), act);
        send_item(compose(REQ_LOOKUP, r16(), r16(), r16(), r48(), r32(), r32(), r32()), act);
        send_item(compose(REQ_PKT, 16'h0006, PTYPE_IPV4, PKT_OP_REQUEST, r48(), r32(), '0,
                          r32()), act);
        in_valid <= 1'b0;
        await_results();

        apply_settings('1, '1);
        run_random(325, 1'b0);
        apply_settings(r48(), ip_pool[3]);
        run_random(325, 1'b1);
        apply_settings('0, r32());
        run_random(325, 1'b0);
        apply_settings(r48(), '0);
        run_random(325, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d items in, %0d results out over %0d register settings, %0d table entries",
                 items_in, tracker.results_seen, settings_applied + 1, tracker.cached_count);
        $display("replies %0d, requests %0d, lookups %0d, stores %0d, table full %0d, ignored %0d",
                 tracker.action_tally[ACT_REPLY], tracker.action_tally[ACT_REQUEST],
                 tracker.action_tally[ACT_LOOKUP], tracker.action_tally[ACT_WRITTEN],
                 tracker.action_tally[ACT_FULL], tracker.action_tally[ACT_IGNORED]);
        if (tracker.mismatches == 0 && tracker.owed_results.size() == 0)
            $display("PASS arp_responder_with_cache");
        else
            $display("FAIL arp_responder_with_cache");
        $finish;
    end

endmodule
